FILE: sv/life_like_automaton_engine_unit_defines.svh
// assertion macros for the life-like automaton engine
`ifndef LIFE_LIKE_AUTOMATON_ENGINE_UNIT_DEFINES_SVH
`define LIFE_LIKE_AUTOMATON_ENGINE_UNIT_DEFINES_SVH
// same-cycle implication, clocked on clk and quiet in reset
`define LLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define LLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: sv/lle_pkg.sv
// shared types and constants of the life-like automaton engine
`default_nettype none
package lle_pkg;
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int SIZE_W   = 7;
	localparam int MASK_W   = 9;
	localparam int POP_W    = 13;
	localparam int CFG_IDX_W = 2;
	localparam logic [POP_W-1:0] POP_MAX = '1;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_STEP  = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BIRTH   = 2'd0,
		REG_SURVIVE = 2'd1,
		REG_ROWS    = 2'd2,
		REG_COLS    = 2'd3
	} reg_idx_t;

	typedef enum logic [10:0] {
		ST_CLR  = 11'b00000000001,
		ST_IDLE = 11'b00000000010,
		ST_WR   = 11'b00000000100,
		ST_RD   = 11'b00000001000,
		ST_LD0  = 11'b00000010000,
		ST_LD1  = 11'b00000100000,
		ST_LD2  = 11'b00001000000,
		ST_LD3  = 11'b00010000000,
		ST_CELL = 11'b00100000000,
		ST_ADV  = 11'b01000000000,
		ST_LDN  = 11'b10000000000
	} state_t;
endpackage
`default_nettype wire

FILE: sv/lle_channels.sv
// valid/ready channel interfaces for commands and results
`default_nettype none
interface lle_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 kind;
	logic [lle_pkg::ROW_W-1:0]  row;
	logic [lle_pkg::COL_W-1:0]  col;
	logic                       new_value;
	modport source(output valid, kind, row, col, new_value, input ready);
	modport sink(input valid, kind, row, col, new_value, output ready);
endinterface

interface lle_res_if;
	logic                       valid;
	logic                       ready;
	logic                       cell_state;
	logic [lle_pkg::POP_W-1:0]  live_count;
	logic                       all_dead;
	modport source(output valid, cell_state, live_count, all_dead, input ready);
	modport sink(input valid, cell_state, live_count, all_dead, output ready);
endinterface
`default_nettype wire

FILE: sv/life_like_automaton_engine_unit.sv
// top level of the life-like automaton engine on a toroidal grid
`default_nettype none
`include "life_like_automaton_engine_unit_defines.svh"
// The grid lives in a row-wide memory (one row per word, one port read and one
// write per cycle). After reset a clearing pass zeroes every row of the grid and
// no command is taken meanwhile; configuration writes are taken at any time. A
// write or read command reads the row of its cell, then writes it back or
// returns the cell; an unused kind or an address outside the grid in use gives
// its result on acceptance. A step loads three row buffers in states LD0 to
// LD3, then one shared neighbour-count unit settles one cell per cycle, the
// finished row being written back with its last cell, and after each row but
// the last, ADV and LDN fetch the next row below and shift the buffers. One
// result per command; new commands wait until the last result is taken.
module life_like_automaton_engine_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	lle_cmd_if.sink                              in_ch,
	lle_res_if.source                            out_ch,
	input  wire logic                            cfg_we,
	input  wire logic [lle_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lle_pkg::MASK_W-1:0]      cfg_data
);
	localparam int RW = lle_pkg::ROW_W;
	localparam int CW = lle_pkg::COL_W;
	localparam int SW = lle_pkg::SIZE_W;
	localparam int NC = lle_pkg::MAX_COLS;

	lle_pkg::state_t state_q;
	logic [lle_pkg::MASK_W-1:0] birth_q, survive_q;
	logic [SW-1:0] rows_cfg_q, cols_cfg_q;
	logic [SW-1:0] rows_eff, cols_eff;
	logic [NC-1:0] grid_mem [lle_pkg::MAX_ROWS];
	logic [NC-1:0] rd_q;
	logic          mem_we, mem_re;
	logic [RW-1:0] mem_wa, mem_ra;
	logic [NC-1:0] mem_wd;
	logic [NC-1:0] prev_q, cur_q, nxt_q, save_q, nrow_q;
	logic [RW-1:0] r_q;
	logic [CW-1:0] c_q;
	logic [RW-1:0] op_row_q;
	logic [CW-1:0] op_col_q;
	logic          op_val_q;
	logic          use_save_q;
	logic [lle_pkg::POP_W-1:0] cnt_q, pop_q;
	logic          o_valid_q, o_cell_q;
	logic          res_load, res_cell;
	logic          in_acc, in_grid;
	logic [SW-1:0] rows_m1, cols_m1, r_nxt, dn_idx;
	logic [CW-1:0] lf, rt;
	logic [3:0]    ncount;
	logic [lle_pkg::MASK_W-1:0] rule;
	logic          new_bit, last_col, last_row;

	// effective grid size, clamped to 3..max
	always_comb begin
		if (rows_cfg_q < SW'(3)) rows_eff = SW'(3);
		else if (rows_cfg_q > SW'(lle_pkg::MAX_ROWS)) rows_eff = SW'(lle_pkg::MAX_ROWS);
		else rows_eff = rows_cfg_q;
		if (cols_cfg_q < SW'(3)) cols_eff = SW'(3);
		else if (cols_cfg_q > SW'(NC)) cols_eff = SW'(NC);
		else cols_eff = cols_cfg_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			birth_q    <= lle_pkg::MASK_W'(8);
			survive_q  <= lle_pkg::MASK_W'(12);
			rows_cfg_q <= SW'(64);
			cols_cfg_q <= SW'(64);
		end else if (cfg_we) begin
			unique case (lle_pkg::reg_idx_t'(cfg_index))
				lle_pkg::REG_BIRTH:   birth_q    <= cfg_data;
				lle_pkg::REG_SURVIVE: survive_q  <= cfg_data;
				lle_pkg::REG_ROWS:    rows_cfg_q <= cfg_data[SW-1:0];
				lle_pkg::REG_COLS:    cols_cfg_q <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = (state_q == lle_pkg::ST_IDLE) && (!o_valid_q || out_ch.ready);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign in_grid = ({1'b0, in_ch.row} < rows_eff) && ({1'b0, in_ch.col} < cols_eff);

	assign rows_m1  = rows_eff - SW'(1);
	assign cols_m1  = cols_eff - SW'(1);
	assign r_nxt    = {1'b0, r_q} + SW'(1);
	assign dn_idx   = r_nxt + SW'(1);
	assign last_col = ({1'b0, c_q} == cols_m1);
	assign last_row = ({1'b0, r_q} == rows_m1);

	// shared neighbour-count unit over the three row buffers
	always_comb begin
		lf = (c_q == '0) ? cols_m1[CW-1:0] : c_q - CW'(1);
		rt = last_col ? '0 : c_q + CW'(1);
		ncount = 4'(prev_q[lf]) + 4'(prev_q[c_q]) + 4'(prev_q[rt])
		       + 4'(cur_q[lf]) + 4'(cur_q[rt])
		       + 4'(nxt_q[lf]) + 4'(nxt_q[c_q]) + 4'(nxt_q[rt]);
		rule = cur_q[c_q] ? survive_q : birth_q;
		new_bit = rule[ncount];
	end

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = r_q;
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = in_ch.row;
		unique case (state_q)
			lle_pkg::ST_CLR: mem_we = 1'b1;
			lle_pkg::ST_IDLE: begin
				if (in_acc && (in_ch.kind == lle_pkg::KIND_STEP)) begin
					mem_re = 1'b1;
					mem_ra = rows_m1[RW-1:0];
				end else if (in_acc) begin
					mem_re = 1'b1;
				end
			end
			lle_pkg::ST_WR: begin
				mem_we = 1'b1;
				mem_wa = op_row_q;
				mem_wd = rd_q;
				mem_wd[op_col_q] = op_val_q;
			end
			lle_pkg::ST_LD1: begin
				mem_re = 1'b1;
				mem_ra = '0;
			end
			lle_pkg::ST_LD2: begin
				mem_re = 1'b1;
				mem_ra = RW'(1);
			end
			lle_pkg::ST_CELL: begin
				if (last_col) begin
					mem_we = 1'b1;
					mem_wd = nrow_q;
					mem_wd[c_q] = new_bit;
				end
			end
			lle_pkg::ST_ADV: begin
				mem_re = !last_row && (dn_idx != rows_eff);
				mem_ra = dn_idx[RW-1:0];
			end
			default: ;
		endcase
	end

	// grid memory, one row per word
	always_ff @(posedge clk) begin
		if (mem_we) grid_mem[mem_wa] <= mem_wd;
		if (mem_re) rd_q <= grid_mem[mem_ra];
	end

	// result load for each finished command
	always_comb begin
		res_load = 1'b0;
		res_cell = 1'b0;
		unique case (state_q)
			lle_pkg::ST_IDLE: res_load = in_acc && ((in_ch.kind == lle_pkg::KIND_NONE)
				|| ((in_ch.kind != lle_pkg::KIND_STEP) && !in_grid));
			lle_pkg::ST_WR: res_load = 1'b1;
			lle_pkg::ST_RD: begin
				res_load = 1'b1;
				res_cell = rd_q[op_col_q];
			end
			lle_pkg::ST_ADV: res_load = last_row;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
			o_cell_q  <= 1'b0;
		end else if (res_load) begin
			o_valid_q <= 1'b1;
			o_cell_q  <= res_cell;
		end else if (out_ch.ready) begin
			o_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lle_pkg::ST_CLR;
			r_q       <= '0;
			c_q       <= '0;
			cnt_q     <= '0;
			pop_q     <= '0;
		end else begin
			unique case (state_q)
				lle_pkg::ST_CLR: begin
					r_q <= r_q + RW'(1);
					if (r_q == RW'(lle_pkg::MAX_ROWS - 1)) state_q <= lle_pkg::ST_IDLE;
				end
				lle_pkg::ST_IDLE: begin
					if (in_acc) begin
						unique case (lle_pkg::kind_t'(in_ch.kind))
							lle_pkg::KIND_STEP: begin
								r_q     <= '0;
								cnt_q   <= '0;
								state_q <= lle_pkg::ST_LD0;
							end
							lle_pkg::KIND_WRITE, lle_pkg::KIND_READ: begin
								if (in_grid) begin
									state_q <= (in_ch.kind == lle_pkg::KIND_WRITE) ?
										lle_pkg::ST_WR : lle_pkg::ST_RD;
								end
							end
							default: ;
						endcase
					end
				end
				lle_pkg::ST_WR: state_q <= lle_pkg::ST_IDLE;
				lle_pkg::ST_RD: state_q <= lle_pkg::ST_IDLE;
				lle_pkg::ST_LD0: state_q <= lle_pkg::ST_LD1;
				lle_pkg::ST_LD1: state_q <= lle_pkg::ST_LD2;
				lle_pkg::ST_LD2: state_q <= lle_pkg::ST_LD3;
				lle_pkg::ST_LD3: begin
					c_q     <= '0;
					state_q <= lle_pkg::ST_CELL;
				end
				lle_pkg::ST_CELL: begin
					if (new_bit && (cnt_q != lle_pkg::POP_MAX)) cnt_q <= cnt_q + 1'b1;
					c_q <= c_q + CW'(1);
					if (last_col) state_q <= lle_pkg::ST_ADV;
				end
				lle_pkg::ST_ADV: begin
					if (last_row) begin
						pop_q   <= cnt_q;
						state_q <= lle_pkg::ST_IDLE;
					end else begin
						r_q     <= r_nxt[RW-1:0];
						state_q <= lle_pkg::ST_LDN;
					end
				end
				lle_pkg::ST_LDN: begin
					c_q     <= '0;
					state_q <= lle_pkg::ST_CELL;
				end
				default: state_q <= lle_pkg::ST_IDLE;
			endcase
		end
	end

	// row buffers and command fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_row_q <= in_ch.row;
			op_col_q <= in_ch.col;
			op_val_q <= in_ch.new_value;
		end
		unique case (state_q)
			lle_pkg::ST_LD1: prev_q <= rd_q;
			lle_pkg::ST_LD2: begin
				cur_q  <= rd_q;
				save_q <= rd_q;
			end
			lle_pkg::ST_LD3: begin
				nxt_q  <= rd_q;
				nrow_q <= cur_q;
			end
			lle_pkg::ST_CELL: nrow_q[c_q] <= new_bit;
			lle_pkg::ST_ADV: begin
				prev_q     <= cur_q;
				cur_q      <= nxt_q;
				use_save_q <= (dn_idx == rows_eff);
			end
			lle_pkg::ST_LDN: begin
				nxt_q  <= use_save_q ? save_q : rd_q;
				nrow_q <= cur_q;
			end
			default: ;
		endcase
	end

	assign out_ch.valid      = o_valid_q;
	assign out_ch.cell_state = o_cell_q;
	assign out_ch.live_count = pop_q;
	assign out_ch.all_dead   = (pop_q == '0);

	// checks on the sequencer
	`LLE_ASSERT_NOW(a_ready_idle, in_ch.ready, state_q == lle_pkg::ST_IDLE, "ready outside idle")
	`LLE_ASSERT_NEXT(a_accept_works, in_acc, (state_q != lle_pkg::ST_IDLE) || o_valid_q, "transfer dropped")
	`LLE_ASSERT_NOW(a_col_range, state_q == lle_pkg::ST_CELL, {1'b0, c_q} < cols_eff, "column overrun")
endmodule
`default_nettype wire

FILE: tb/life_like_automaton_engine_unit_tb.sv
// self-checking testbench of the life-like automaton engine with a grid-predicting scoreboard
`timescale 1ns / 100ps
`default_nettype none

module life_like_automaton_engine_unit_tb;
	typedef struct {
		logic                      cell_state;
		logic [lle_pkg::POP_W-1:0] live_count;
		logic                      all_dead;
	} cell_result_t;

	// predicts the grid and holds the results still due from the block
	class automaton_scoreboard;
		bit [lle_pkg::MAX_COLS-1:0] cells [lle_pkg::MAX_ROWS];
		bit [lle_pkg::MAX_COLS-1:0] stepped [lle_pkg::MAX_ROWS];
		logic [lle_pkg::POP_W-1:0]  population;
		logic [lle_pkg::MASK_W-1:0] birth;
		logic [lle_pkg::MASK_W-1:0] survive;
		logic [lle_pkg::SIZE_W-1:0] rows_reg;
		logic [lle_pkg::SIZE_W-1:0] cols_reg;
		cell_result_t               due_results[$];
		int                         mismatches;
		int                         checked;
		int                         generations;

		function new();
			foreach (cells[r]) cells[r] = '0;
			population  = '0;
			birth       = 9'd8;
			survive     = 9'd12;
			rows_reg    = 7'd64;
			cols_reg    = 7'd64;
			mismatches  = 0;
			checked     = 0;
			generations = 0;
		endfunction

		function int clamp_size(logic [lle_pkg::SIZE_W-1:0] v, int maxv);
			if (v < 3) return 3;
			if (v > maxv) return maxv;
			return int'(v);
		endfunction

		function int rows_used();
			return clamp_size(rows_reg, lle_pkg::MAX_ROWS);
		endfunction

		function int cols_used();
			return clamp_size(cols_reg, lle_pkg::MAX_COLS);
		endfunction

		function void set_reg(lle_pkg::reg_idx_t idx, logic [lle_pkg::MASK_W-1:0] data);
			case (idx)
				lle_pkg::REG_BIRTH:   birth = data;
				lle_pkg::REG_SURVIVE: survive = data;
				lle_pkg::REG_ROWS:    rows_reg = data[lle_pkg::SIZE_W-1:0];
				lle_pkg::REG_COLS:    cols_reg = data[lle_pkg::SIZE_W-1:0];
				default: ;
			endcase
		endfunction

		// one generation over the grid in use, edges wrapped round
		function void advance_generation();
			int nr, nc, up, dn, lf, rt, n, live;
			logic [lle_pkg::MASK_W-1:0] mask;
			nr   = rows_used();
			nc   = cols_used();
			live = 0;
			for (int r = 0; r < nr; r++) begin
				up = (r == 0) ? nr - 1 : r - 1;
				dn = (r + 1 == nr) ? 0 : r + 1;
				for (int c = 0; c < nc; c++) begin
					lf = (c == 0) ? nc - 1 : c - 1;
					rt = (c + 1 == nc) ? 0 : c + 1;
					n = cells[up][lf] + cells[up][c] + cells[up][rt] + cells[r][lf]
						+ cells[r][rt] + cells[dn][lf] + cells[dn][c] + cells[dn][rt];
					mask = cells[r][c] ? survive : birth;
					stepped[r][c] = mask[n];
				end
			end
			for (int r = 0; r < nr; r++)
				for (int c = 0; c < nc; c++) begin
					cells[r][c] = stepped[r][c];
					if (cells[r][c] && live < 8191) live++;
				end
			population = live[lle_pkg::POP_W-1:0];
			generations++;
		endfunction

		function void note_command(logic [1:0] kind, logic [lle_pkg::ROW_W-1:0] row,
				logic [lle_pkg::COL_W-1:0] col, logic value);
			cell_result_t res;
			bit in_grid;
			in_grid = (row < rows_used()) && (col < cols_used());
			res.cell_state = 1'b0;
			case (kind)
				lle_pkg::KIND_WRITE: if (in_grid) cells[row][col] = value;
				lle_pkg::KIND_STEP:  advance_generation();
				lle_pkg::KIND_READ:  if (in_grid) res.cell_state = cells[row][col];
				default: ;
			endcase
			res.live_count = population;
			res.all_dead   = (population == 0);
			due_results.push_back(res);
		endfunction

		function void check_result(logic cs, logic [lle_pkg::POP_W-1:0] lc, logic ad);
			cell_result_t want;
			checked++;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: cell %0b count %0d dead %0b",
						cs, lc, ad);
				return;
			end
			want = due_results.pop_front();
			if (cs !== want.cell_state || lc !== want.live_count || ad !== want.all_dead)
			begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: expected cell %0b count %0d dead %0b, got %0b %0d %0b",
						checked, want.cell_state, want.live_count, want.all_dead, cs, lc, ad);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [lle_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [lle_pkg::MASK_W-1:0] cfg_data;
	int send_idle_pct;
	int recv_idle_pct;
	int cycle_count;
	int sent_items;
	automaton_scoreboard sb;

	lle_cmd_if cmd_ch();
	lle_res_if res_ch();

	life_like_automaton_engine_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (cmd_ch),
		.out_ch    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side stalls at random
	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// result transfers
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.cell_state, res_ch.live_count, res_ch.all_dead);
	end

	// one command transfer; valid is left high for a following command
	task automatic put_cmd(lle_pkg::kind_t kind, logic [lle_pkg::ROW_W-1:0] row,
			logic [lle_pkg::COL_W-1:0] col, logic value);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.kind      <= kind;
		cmd_ch.row       <= row;
		cmd_ch.col       <= col;
		cmd_ch.new_value <= value;
		do @(posedge clk); while (!cmd_ch.ready);
		sb.note_command(kind, row, col, value);
		sent_items++;
	endtask

	// wait for every due result, then let the block settle
	task automatic drain();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (sb.due_results.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(lle_pkg::reg_idx_t idx, logic [lle_pkg::MASK_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, data);
	endtask

	task automatic set_rule(logic [lle_pkg::MASK_W-1:0] b, logic [lle_pkg::MASK_W-1:0] s,
			logic [lle_pkg::MASK_W-1:0] r, logic [lle_pkg::MASK_W-1:0] c);
		write_reg(lle_pkg::REG_BIRTH, b);
		write_reg(lle_pkg::REG_SURVIVE, s);
		write_reg(lle_pkg::REG_ROWS, r);
		write_reg(lle_pkg::REG_COLS, c);
	endtask

	// mostly cell traffic inside the grid in use, with a step now and then
	task automatic random_cmds(int n);
		int pick;
		logic [lle_pkg::ROW_W-1:0] r;
		logic [lle_pkg::COL_W-1:0] c;
		logic v;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if ($urandom_range(3) == 0) begin
				r = lle_pkg::ROW_W'($urandom_range(63));
				c = lle_pkg::COL_W'($urandom_range(63));
			end else begin
				r = lle_pkg::ROW_W'($urandom_range(sb.rows_used() - 1));
				c = lle_pkg::COL_W'($urandom_range(sb.cols_used() - 1));
			end
			v = 1'($urandom_range(1));
			if (pick < 50)
				put_cmd(lle_pkg::KIND_WRITE, r, c, v);
			else if (pick < 78)
				put_cmd(lle_pkg::KIND_READ, r, c, v);
			else if (pick < 95)
				put_cmd(lle_pkg::KIND_STEP, r, c, v);
			else
				put_cmd(lle_pkg::KIND_NONE, r, c, v);
		end
	endtask

	initial begin
		sb = new();
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = lle_pkg::REG_BIRTH;
		cfg_data         = '0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.kind      = lle_pkg::KIND_WRITE;
		cmd_ch.row       = '0;
		cmd_ch.col       = '0;
		cmd_ch.new_value = 1'b0;
		res_ch.ready     = 1'b0;
		cycle_count      = 0;
		sent_items       = 0;
		send_idle_pct    = 0;
		recv_idle_pct    = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// blinker across the corner of the full grid, default rule
		put_cmd(lle_pkg::KIND_READ, 6'd0, 6'd0, 1'b0);
		put_cmd(lle_pkg::KIND_WRITE, 6'd63, 6'd63, 1'b1);
		put_cmd(lle_pkg::KIND_WRITE, 6'd0, 6'd63, 1'b1);
		put_cmd(lle_pkg::KIND_WRITE, 6'd1, 6'd63, 1'b1);
		put_cmd(lle_pkg::KIND_STEP, 6'd0, 6'd0, 1'b0);
		put_cmd(lle_pkg::KIND_READ, 6'd0, 6'd62, 1'b0);
		put_cmd(lle_pkg::KIND_READ, 6'd0, 6'd0, 1'b1);
		put_cmd(lle_pkg::KIND_READ, 6'd63, 6'd63, 1'b0);
		put_cmd(lle_pkg::KIND_NONE, 6'd63, 6'd63, 1'b1);
		drain();

		// sizes clamped from both sides, extreme masks, addresses outside the grid
		set_rule(9'h1FF, 9'h000, 9'h07F, 9'h000);
		put_cmd(lle_pkg::KIND_WRITE, 6'd10, 6'd3, 1'b1);
		put_cmd(lle_pkg::KIND_READ, 6'd10, 6'd3, 1'b0);
		put_cmd(lle_pkg::KIND_WRITE, 6'd10, 6'd2, 1'b1);
		put_cmd(lle_pkg::KIND_STEP, 6'd0, 6'd0, 1'b0);
		put_cmd(lle_pkg::KIND_READ, 6'd10, 6'd2, 1'b0);
		drain();
		set_rule(9'h000, 9'h1FF, 9'h003, 9'h005);
		put_cmd(lle_pkg::KIND_WRITE, 6'd2, 6'd4, 1'b1);
		put_cmd(lle_pkg::KIND_WRITE, 6'd1, 6'd1, 1'b1);
		put_cmd(lle_pkg::KIND_STEP, 6'd0, 6'd0, 1'b0);
		put_cmd(lle_pkg::KIND_STEP, 6'd0, 6'd0, 1'b0);
		put_cmd(lle_pkg::KIND_WRITE, 6'd2, 6'd4, 1'b0);
		put_cmd(lle_pkg::KIND_WRITE, 6'd1, 6'd1, 1'b0);
		put_cmd(lle_pkg::KIND_STEP, 6'd0, 6'd0, 1'b0);
		drain();

		// random traffic in three idling regimes with varied rules and sizes
		send_idle_pct = 21;
		recv_idle_pct = 86;
		set_rule(9'd8, 9'd12, 9'd6, 9'd7);
		random_cmds(40);
		drain();
		send_idle_pct = 86;
		recv_idle_pct = 21;
		set_rule(lle_pkg::MASK_W'($urandom_range(511)), lle_pkg::MASK_W'($urandom_range(511)),
			lle_pkg::MASK_W'($urandom_range(3, 12)), lle_pkg::MASK_W'($urandom_range(3, 12)));
		random_cmds(40);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_rule(9'h048, 9'h00C, 9'd3, 9'd3);
		random_cmds(25);
		drain();
		set_rule(lle_pkg::MASK_W'($urandom_range(511)), lle_pkg::MASK_W'($urandom_range(511)),
			9'd64, 9'd64);
		random_cmds(15);
		drain();
		repeat (20) @(negedge clk);

		$display("ran %0d commands, %0d results checked, %0d generations predicted",
			sent_items, sb.checked, sb.generations);
		$display("mismatches: %0d, results still due: %0d", sb.mismatches,
			sb.due_results.size());
		if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

`default_nettype wire
